>>> src/ahfd_pkg.sv
// Shared types, codes and helpers for the ASCII hex frame deframer.
package ahfd_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_ANALOG  = 2'd0;
    localparam kind_t KIND_DIGITAL = 2'd1;
    localparam kind_t KIND_MODE    = 2'd2;
    localparam kind_t KIND_ERROR   = 2'd3;

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_START_CHAR    = 2'd0;
    localparam reg_idx_t REG_STOP_CHAR     = 2'd1;
    localparam reg_idx_t REG_ANALOG_COUNT  = 2'd2;
    localparam reg_idx_t REG_DIGITAL_COUNT = 2'd3;

    localparam logic [7:0] RST_START_CHAR    = 8'd35;
    localparam logic [7:0] RST_STOP_CHAR     = 8'd10;
    localparam logic [3:0] RST_ANALOG_COUNT  = 4'd6;
    localparam logic [4:0] RST_DIGITAL_COUNT = 5'd14;

    // Controls of the shared hex accumulator
    typedef struct packed {
        logic clear;
        logic shift;
    } hex_ctrl_t;

    // ASCII hex digit to nibble; anything else reads as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c > 8'd47 && c < 8'd58) begin
            d = c - 8'd48;
        end else if (c > 8'd64 && c < 8'd71) begin
            d = c - 8'd55;
        end else if (c > 8'd96 && c < 8'd103) begin
            d = c - 8'd87;
        end
        return d[3:0];
    endfunction

    // Low pin mask; sixteen or more keeps the whole word
    function automatic logic [15:0] pin_mask(input logic [4:0] count);
        logic [15:0] m;
        if (count >= 5'd16) begin
            m = 16'hFFFF;
        end else begin
            m = (16'd1 << count[3:0]) - 16'd1;
        end
        return m;
    endfunction

endpackage

>>> src/ahfd_window_ram.sv
// Byte window storage: one write port, one registered read port.
module ahfd_window_ram
    import ahfd_pkg::*;
#(
    parameter int DEPTH = 42,
    parameter int AW    = 6
)
(
    input  logic          clk,
    input  logic          wen,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/ahfd_hex_acc.sv
// Shared hex digit decoder and 16-bit shift accumulator.
module ahfd_hex_acc
    import ahfd_pkg::*;
(
    input  logic       clk,
    input  hex_ctrl_t  ctrl,
    input  logic [7:0] char_in,
    output logic [15:0] word
);

    logic [15:0] acc_reg;
    logic [15:0] acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = 16'd0;
        end
        else if (ctrl.shift)
        begin
            acc_next = {acc_reg[11:0], hex_nibble(char_in)};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign word = acc_reg;

endmodule

>>> src/ascii_hex_frame_deframer.sv
// Top level of the ASCII hex frame deframer: config port, sequencer, output register.
//
//  channel   handshake                 payload                        direction
//  -------   ------------------------  -----------------------------  ---------
//  config    psel/penable/pwrite/pready paddr, pwdata, prdata         in/out
//  rx        in_valid / in_ready       rx_byte                        in
//  result    out_valid / out_ready     kind, channel, value, last     out
//
// A byte other than the stop character is taken and leaves the sequencer idle, ready
// for the next byte. A stop byte that fails the length or fill check goes straight to
// the output step; one that passes has the start position read and checked, and a
// wrong start character goes to the output step. A good frame of n analog words gives
// n+2 words, each loaded into the output register after one pass of the shared hex
// accumulator per digit, fed one byte a cycle from the window RAM read port.
// Reset restores the register defaults and clears the window fill count and the
// pointers; the window RAM itself is never cleared, the fill count tells which bytes
// count. A stalled result holds the sequencer in its output step; a non-stop byte
// is still taken while the last result of a frame waits to be taken.
module ascii_hex_frame_deframer
    import ahfd_pkg::*;
#(
    parameter int MAX_ANALOG   = 8,
    parameter int WINDOW_BYTES = 42
)
(
    input  logic        clk,
    input  logic        rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // received bytes
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    // decoded results
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [2:0]  channel,
    output logic [15:0] value,
    output logic        last
);

    localparam int PTR_W  = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
    localparam int FILL_W = $clog2(WINDOW_BYTES + 1);
    localparam int NW     = $clog2(MAX_ANALOG + 1);
    localparam int WIDX_W = $clog2(MAX_ANALOG + 2);
    localparam int LEN_W  = $clog2(4 * MAX_ANALOG + 11);
    localparam int CW     = $clog2(WINDOW_BYTES + 4 * MAX_ANALOG + 11);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_CHECK,
        ST_DEC,
        ST_PUT
    } state_t;

    // Configuration registers
    logic [7:0] start_char_reg;
    logic [7:0] stop_char_reg;
    logic [3:0] analog_count_reg;
    logic [4:0] digital_count_reg;

    // Sequencer and window bookkeeping
    state_t            state_reg;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [1:0]        digit_reg;
    logic [WIDX_W-1:0] word_idx_reg;
    logic              err_reg;

    // Output register
    logic        out_valid_reg;
    kind_t       kind_reg;
    logic [2:0]  channel_reg;
    logic [15:0] value_reg;
    logic        last_reg;

    // Datapath wires
    logic              in_fire;
    logic              out_free;
    logic              cfg_write;
    logic [NW-1:0]     n_eff;
    logic [LEN_W-1:0]  frame_len;
    logic [FILL_W-1:0] fill_next;
    logic              len_bad;
    logic [CW-1:0]     wr_ext;
    logic [CW-1:0]     len_m1;
    logic [PTR_W-1:0]  start_ptr;
    logic [PTR_W-1:0]  rd_ptr_inc;
    logic [PTR_W-1:0]  wr_ptr_inc;
    logic [7:0]        ram_rdata;
    logic [15:0]       acc_word;
    hex_ctrl_t         hex_ctrl;
    logic [WIDX_W-1:0] n_ext;
    kind_t             word_kind;
    logic              word_last;
    logic [15:0]       word_val;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Register read-back
    always_comb
    begin
        prdata = 32'd0;
        unique case (reg_idx_t'(paddr[3:2]))
            REG_START_CHAR:    prdata = {24'd0, start_char_reg};
            REG_STOP_CHAR:     prdata = {24'd0, stop_char_reg};
            REG_ANALOG_COUNT:  prdata = {28'd0, analog_count_reg};
            REG_DIGITAL_COUNT: prdata = {27'd0, digital_count_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // Frame geometry: clamp the analog count, frame length 4n+10
    assign n_eff     = NW'((int'(analog_count_reg) > MAX_ANALOG) ?
                           MAX_ANALOG : int'(analog_count_reg));
    assign frame_len = LEN_W'(4 * int'(n_eff) + 10);
    assign fill_next = (int'(fill_reg) >= WINDOW_BYTES) ? fill_reg : fill_reg + 1'b1;
    assign len_bad   = (CW'(frame_len) > CW'(WINDOW_BYTES)) ||
                       (CW'(fill_next) < CW'(frame_len));

    // Start character sits frame_len-1 places behind the stop byte
    assign wr_ext    = CW'(wr_ptr_reg);
    assign len_m1    = CW'(frame_len) - 1'b1;
    assign start_ptr = (wr_ext >= len_m1) ? PTR_W'(wr_ext - len_m1)
                                          : PTR_W'(wr_ext + CW'(WINDOW_BYTES) - len_m1);

    assign rd_ptr_inc = (int'(rd_ptr_reg) == WINDOW_BYTES - 1) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_ptr_inc = (int'(wr_ptr_reg) == WINDOW_BYTES - 1) ? '0 : wr_ptr_reg + 1'b1;

    // Classify the word just assembled
    assign n_ext = WIDX_W'(n_eff);
    always_comb
    begin
        word_kind = KIND_ANALOG;
        word_last = 1'b0;
        word_val  = acc_word;
        if (word_idx_reg == n_ext)
        begin
            word_kind = KIND_DIGITAL;
            word_val  = acc_word & pin_mask(digital_count_reg);
        end
        else if (word_idx_reg > n_ext)
        begin
            word_kind = KIND_MODE;
            word_last = 1'b1;
            word_val  = acc_word & pin_mask(digital_count_reg);
        end
    end

    always_comb
    begin
        hex_ctrl.clear = (state_reg == ST_CHECK);
        hex_ctrl.shift = (state_reg == ST_DEC);
    end

    ahfd_window_ram #(
        .DEPTH (WINDOW_BYTES),
        .AW    (PTR_W)
    ) u_ram (
        .clk   (clk),
        .wen   (in_fire),
        .waddr (wr_ptr_reg),
        .wdata (rx_byte),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    ahfd_hex_acc u_hex (
        .clk     (clk),
        .ctrl    (hex_ctrl),
        .char_in (ram_rdata),
        .word    (acc_word)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_char_reg    <= RST_START_CHAR;
            stop_char_reg     <= RST_STOP_CHAR;
            analog_count_reg  <= RST_ANALOG_COUNT;
            digital_count_reg <= RST_DIGITAL_COUNT;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_START_CHAR:    start_char_reg    <= pwdata[7:0];
                REG_STOP_CHAR:     stop_char_reg     <= pwdata[7:0];
                REG_ANALOG_COUNT:  analog_count_reg  <= pwdata[3:0];
                REG_DIGITAL_COUNT: digital_count_reg <= pwdata[4:0];
                default:           ;
            endcase
        end
    end

    // Sequencer: take bytes, check the frame, walk the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fill_reg      <= '0;
            digit_reg     <= '0;
            word_idx_reg  <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_ANALOG;
            channel_reg   <= '0;
            value_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            // drop the result once it is taken, unless the output step refills it
            if (out_valid_reg && out_ready && state_reg != ST_PUT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        wr_ptr_reg <= wr_ptr_inc;
                        fill_reg   <= fill_next;
                        if (rx_byte == stop_char_reg)
                        begin
                            if (len_bad)
                            begin
                                err_reg   <= 1'b1;
                                state_reg <= ST_PUT;
                            end
                            else
                            begin
                                err_reg    <= 1'b0;
                                rd_ptr_reg <= start_ptr;
                                state_reg  <= ST_PRIME;
                            end
                        end
                    end
                end
                ST_PRIME:
                begin
                    // read of the start position is under way
                    rd_ptr_reg <= rd_ptr_inc;
                    state_reg  <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (ram_rdata != start_char_reg)
                    begin
                        err_reg   <= 1'b1;
                        state_reg <= ST_PUT;
                    end
                    else
                    begin
                        rd_ptr_reg   <= rd_ptr_inc;
                        digit_reg    <= '0;
                        word_idx_reg <= '0;
                        state_reg    <= ST_DEC;
                    end
                end
                ST_DEC:
                begin
                    digit_reg <= digit_reg + 1'b1;
                    if (digit_reg == 2'd3)
                    begin
                        // hold the pointer so the next byte waits in the read register
                        state_reg <= ST_PUT;
                    end
                    else
                    begin
                        rd_ptr_reg <= rd_ptr_inc;
                    end
                end
                ST_PUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (err_reg)
                        begin
                            kind_reg    <= KIND_ERROR;
                            channel_reg <= '0;
                            value_reg   <= '0;
                            last_reg    <= 1'b1;
                            err_reg     <= 1'b0;
                            fill_reg    <= '0;
                            state_reg   <= ST_IDLE;
                        end
                        else
                        begin
                            kind_reg    <= word_kind;
                            channel_reg <= (word_kind == KIND_ANALOG) ? word_idx_reg[2:0]
                                                                      : 3'd0;
                            value_reg   <= word_val;
                            last_reg    <= word_last;
                            if (word_last)
                            begin
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                word_idx_reg <= word_idx_reg + 1'b1;
                                digit_reg    <= '0;
                                rd_ptr_reg   <= rd_ptr_inc;
                                state_reg    <= ST_DEC;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign channel   = channel_reg;
    assign value     = value_reg;
    assign last      = last_reg;

    // A framing error always closes the run of results
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_ERROR |-> last_reg && value_reg == 16'd0)
        else $error("framing error result without last or with a value");

    // A non-stop byte causes no work
    a_plain_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && rx_byte != stop_char_reg |=> state_reg == ST_IDLE)
        else $error("non-stop byte started the sequencer");

    // Pointers and fill count stay inside the window
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= WINDOW_BYTES && int'(wr_ptr_reg) < WINDOW_BYTES &&
        int'(rd_ptr_reg) < WINDOW_BYTES)
        else $error("window pointer or fill count out of range");

    // An error result empties the window
    a_err_flush: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUT && err_reg && out_free |=> fill_reg == '0)
        else $error("framing error did not flush the window");

endmodule

>>> tb/tb.sv
// Self-checking testbench for ascii_hex_frame_deframer: decoder model, APB setup, stalls.
module tb
    import ahfd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Geometry of the block under test
    localparam int RX_WINDOW  = 42;
    localparam int ANALOG_CAP = 8;

    // Cycles to let the block settle once the last result has been taken.
    localparam int SETTLE_CYCLES = 64;

    // Give up after this many cycles in which no request is taken on either side
    localparam int QUIET_LIMIT = 4000;

    // Least count of random stimulus bytes sent under each register setting
    localparam int BYTES_PER_SETTING = 33;

    typedef struct {
        kind_t       kind;
        logic [2:0]  channel;
        logic [15:0] value;
        logic        last;
    } frame_result_t;

    // Decoder model plus the queue of results still owed by the block
    class frame_scoreboard;
        logic [7:0]    start_c;
        logic [7:0]    stop_c;
        logic [3:0]    analog_n;
        logic [4:0]    pin_count;
        logic [7:0]    recent [RX_WINDOW];  // index 0 is the newest byte
        int unsigned   fill;
        frame_result_t pending_words [$];
        int            errors;
        int            checked;

        function new();
            start_c   = RST_START_CHAR;
            stop_c    = RST_STOP_CHAR;
            analog_n  = RST_ANALOG_COUNT;
            pin_count = RST_DIGITAL_COUNT;
            errors    = 0;
            checked   = 0;
            flush();
        endfunction

        function void flush();
            foreach (recent[i]) recent[i] = 8'd0;
            fill = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] data);
            case (idx)
                REG_START_CHAR:    start_c   = data[7:0];
                REG_STOP_CHAR:     stop_c    = data[7:0];
                REG_ANALOG_COUNT:  analog_n  = data[3:0];
                REG_DIGITAL_COUNT: pin_count = data[4:0];
                default: ;
            endcase
        endfunction

        function logic [3:0] nibble(logic [7:0] c);
            if (c >= "0" && c <= "9") return 4'(c - "0");
            if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
            if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
            return 4'd0;
        endfunction

        // Four hex characters starting k+1 bytes after the start character
        function logic [15:0] word_at(int unsigned len, int unsigned k);
            logic [15:0] w;
            w = 16'd0;
            for (int unsigned d = 0; d < 4; d++) begin
                w = {w[11:0], nibble(recent[len - 2 - k - d])};
            end
            return w;
        endfunction

        function void queue_word(kind_t k, logic [2:0] ch, logic [15:0] v, logic l);
            frame_result_t r;
            r.kind    = k;
            r.channel = ch;
            r.value   = v;
            r.last    = l;
            pending_words.push_back(r);
        endfunction

        // Shift one taken byte in; on a stop byte, queue the words it releases
        function void absorb_byte(logic [7:0] b);
            int unsigned n;
            int unsigned len;
            logic [16:0] mask;
            for (int i = RX_WINDOW - 1; i > 0; i--) begin
                recent[i] = recent[i - 1];
            end
            recent[0] = b;
            if (fill < RX_WINDOW) fill++;
            if (b != stop_c) return;

            n   = (analog_n > ANALOG_CAP) ? ANALOG_CAP : analog_n;
            len = 4 * n + 10;
            if (len > RX_WINDOW || fill < len || recent[len - 1] != start_c) begin
                queue_word(KIND_ERROR, 3'd0, 16'd0, 1'b1);
                flush();
                return;
            end

            mask = (pin_count >= 5'd16) ? 17'h0FFFF : (17'd1 << pin_count) - 17'd1;
            for (int unsigned k = 0; k < n; k++) begin
                queue_word(KIND_ANALOG, 3'(k), word_at(len, 4 * k), 1'b0);
            end
            queue_word(KIND_DIGITAL, 3'd0, word_at(len, 4 * n) & mask[15:0], 1'b0);
            queue_word(KIND_MODE, 3'd0, word_at(len, 4 * n + 4) & mask[15:0], 1'b1);
        endfunction

        function void check_result(kind_t k, logic [2:0] ch, logic [15:0] v, logic l);
            frame_result_t e;
            checked++;
            if (pending_words.size() == 0) begin
                $error("unexpected result: kind %0d channel %0d value %h last %0b",
                       k, ch, v, l);
                errors++;
                return;
            end
            e = pending_words.pop_front();
            if (k !== e.kind) begin
                $error("kind: expected %0d, actual %0d", e.kind, k);
                errors++;
            end
            if (ch !== e.channel) begin
                $error("channel: expected %0d, actual %0d", e.channel, ch);
                errors++;
            end
            if (v !== e.value) begin
                $error("value: expected %h, actual %h", e.value, v);
                errors++;
            end
            if (l !== e.last) begin
                $error("last: expected %0b, actual %0b", e.last, l);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    kind_t       kind;
    logic [2:0]  channel;
    logic [15:0] value;
    logic        last;

    frame_scoreboard sb;

    int send_idle_pct;
    int recv_idle_pct;
    int bytes_sent;
    int settings_used;
    int quiet_cycles;

    ascii_hex_frame_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .channel   (channel),
        .value     (value),
        .last      (last)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Receiver: stall the result channel at random at the current rate
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: feed every taken byte to the model, check every taken result,
    // and watch for a hang. Outputs are read before this edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                sb.absorb_byte(rx_byte);
            end
            if (out_valid && out_ready) begin
                sb.check_result(kind, channel, value, last);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no request taken for %0d cycles", QUIET_LIMIT);
                $display("ascii_hex_frame_deframer regression: fail");
                $finish;
            end
        end
    end

    // Offer one byte, idling first at the sender's rate; return at the edge
    // that takes it. Valid stays high so a back-to-back byte follows at once.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    // Drop valid, wait until every owed result is in, then let the block settle.
    // Step one edge first so the monitor has absorbed the last byte taken.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_words.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write (setup, access), then read back and compare the register bits
    task automatic program_reg(input reg_idx_t idx, input logic [31:0] data);
        logic [31:0] field_mask;
        logic [31:0] got;
        case (idx)
            REG_ANALOG_COUNT:  field_mask = 32'h0000_000F;
            REG_DIGITAL_COUNT: field_mask = 32'h0000_001F;
            default:           field_mask = 32'h0000_00FF;
        endcase

        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, data);

        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((got & field_mask) !== (data & field_mask)) begin
            $error("register %0d: expected %h, actual %h", idx, data & field_mask,
                   got & field_mask);
            sb.errors++;
        end
    endtask

    task automatic apply_settings(input logic [7:0] start_c, input logic [7:0] stop_c,
                                  input logic [3:0] n, input logic [4:0] pins);
        drain();
        program_reg(REG_START_CHAR, 32'(start_c));
        program_reg(REG_STOP_CHAR, 32'(stop_c));
        program_reg(REG_ANALOG_COUNT, 32'(n));
        program_reg(REG_DIGITAL_COUNT, 32'(pins));
        settings_used++;
    endtask

    function automatic logic [7:0] hex_char();
        int unsigned d;
        d = $urandom_range(15);
        if (d < 10) return 8'("0" + d);
        return $urandom_range(1) ? 8'("A" + d - 10) : 8'("a" + d - 10);
    endfunction

    // Payload byte: mostly hex digits, now and then any byte but the stop byte
    function automatic logic [7:0] body_char();
        logic [7:0] c;
        do begin
            c = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : hex_char();
        end while (c == sb.stop_c);
        return c;
    endfunction

    // Line noise between frames; a stray stop byte can force a framing error
    function automatic logic [7:0] noise_char();
        return ($urandom_range(3) == 0) ? sb.stop_c : 8'($urandom_range(255));
    endfunction

    // One frame: mostly well formed, else truncated, overlong or with a bad opener
    task automatic send_frame();
        int unsigned n;
        int unsigned body;
        int unsigned pick;
        n    = (sb.analog_n > ANALOG_CAP) ? ANALOG_CAP : sb.analog_n;
        body = 4 * n + 8;
        pick = $urandom_range(99);
        if (pick >= 70 && pick < 80) begin
            body = $urandom_range(body - 1);
        end else if (pick >= 90) begin
            body = body + $urandom_range(1, 3);
        end
        repeat ($urandom_range(2)) send_byte(noise_char());
        if (pick >= 80 && pick < 90) begin
            send_byte(sb.start_c ^ 8'($urandom_range(1, 255)));
        end else begin
            send_byte(sb.start_c);
        end
        repeat (body) send_byte(body_char());
        send_byte(sb.stop_c);
    endtask

    // Program a setting, then stream random frames under it
    task automatic run_setting(input logic [7:0] start_c, input logic [7:0] stop_c,
                               input logic [3:0] n, input logic [4:0] pins);
        int first;
        apply_settings(start_c, stop_c, n, pins);
        first = bytes_sent;
        while (bytes_sent - first < BYTES_PER_SETTING) begin
            send_frame();
            // hold the sender now and then until every owed result is back
            if ($urandom_range(7) == 0) begin
                drain();
            end
        end
    endtask

    initial
    begin
        sb            = new();
        send_idle_pct = 21;
        recv_idle_pct = 80;
        bytes_sent    = 0;
        settings_used = 0;
        quiet_cycles  = 0;

        // Drive every input to a known value and hold reset
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= 4'd0;
        pwdata    <= 32'd0;
        in_valid  <= 1'b0;
        rx_byte   <= 8'd0;
        out_ready <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: a stop byte right out of reset has too few bytes behind it
        send_byte(RST_STOP_CHAR);
        // both byte extremes as plain noise
        send_byte(8'h00);
        send_byte(8'hFF);

        // Shortest frame (no analog words), full pin mask. The payload walks the
        // edges of the hex ranges: '/', ':', '@', 'G', '`' and 'g' read as zero.
        apply_settings("#", 8'h0A, 4'd0, 5'd16);
        send_text("#/09:@AFG\n");
        send_byte("#");
        send_byte(8'd96);
        send_text("afgFFFF\n");

        // Random part, first phase: sender idles lightly, receiver stalls hard
        send_idle_pct = 21;
        recv_idle_pct = 80;
        run_setting("#", 8'h0A, 4'd6, 5'd14);
        run_setting(8'h00, 8'hFF, 4'd0, 5'd1);
        // analog count above the cap is clamped to the widest frame
        run_setting("<", ">", 4'd15, 5'd16);

        // Second phase: the other way round
        send_idle_pct = 80;
        recv_idle_pct = 21;
        // empty pin mask
        run_setting(8'hFF, 8'h00, 4'd2, 5'd0);
        // start byte equal to stop byte: the opener itself closes a frame
        run_setting("$", "$", 4'd1, 5'd5);
        // pin count past sixteen keeps the whole word
        run_setting("S", "E", 4'd8, 5'd31);

        // Third phase: no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_setting(":", 8'h0D, 4'd3, 5'd9);
        run_setting("#", 8'h0A, 4'd1, 5'd16);

        drain();

        $display("sent %0d bytes under %0d register settings; %0d results checked",
                 bytes_sent, settings_used + 1, sb.checked);
        $display("covered clamped analog count, start equal to stop, empty and full pin masks");
        if (sb.errors == 0) begin
            $display("ascii_hex_frame_deframer regression: pass");
        end else begin
            $display("ascii_hex_frame_deframer regression: fail");
        end
        $finish;
    end

endmodule
